[rtl/rsi_pkg.sv]
// Shared constants for the ray/sphere intersection pipeline.
// No dependencies; used by rsi_isqrt, rsi_div and ray_sphere_intersection.
`default_nettype none
package rsi_pkg;
  localparam int DEF_FRAC_BITS = 16;  // default fraction bits (Q16.16)
  localparam int ROOT_IN_W     = 64;  // radicand width of the square root unit
  localparam int ROOT_OUT_W    = 32;  // root width
  localparam int NORM_W        = 30;  // normalized magnitude width
  localparam int LEN_W         = 32;  // vector length width (divisor)
  localparam int NORM_LANES    = 3;   // x, y, z
endpackage
`default_nettype wire

[rtl/rsi_isqrt.sv]
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on rsi_pkg for the radicand and root widths.
`default_nettype none
module rsi_isqrt import rsi_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [ROOT_IN_W-1:0]  radicand,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [ROOT_OUT_W-1:0] root,
  output logic [SIDE_W-1:0]     out_side
);
  localparam int STEPS = ROOT_OUT_W;

  logic [ROOT_IN_W-1:0] x_q    [STEPS];
  logic [ROOT_IN_W-1:0] r_q    [STEPS];
  logic [ROOT_IN_W-1:0] x_src  [STEPS];
  logic [ROOT_IN_W-1:0] r_src  [STEPS];
  logic [ROOT_IN_W-1:0] x_next [STEPS];
  logic [ROOT_IN_W-1:0] r_next [STEPS];
  logic [SIDE_W-1:0]    side_q [STEPS];
  logic [STEPS-1:0]     vld;

  always_comb begin
    logic [ROOT_IN_W-1:0] one_bit;
    logic [ROOT_IN_W-1:0] trial;
    x_src[0] = radicand;
    r_src[0] = '0;
    for (int k = 1; k < STEPS; k++) begin
      x_src[k] = x_q[k-1];
      r_src[k] = r_q[k-1];
    end
    for (int k = 0; k < STEPS; k++) begin
      one_bit = {{(ROOT_IN_W-1){1'b0}}, 1'b1} << (ROOT_IN_W - 2 - 2 * k);
      trial   = r_src[k] + one_bit;
      if (x_src[k] >= trial) begin
        x_next[k] = x_src[k] - trial;
        r_next[k] = (r_src[k] >> 1) + one_bit;
      end else begin
        x_next[k] = x_src[k];
        r_next[k] = r_src[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= in_side;
      for (int k = 1; k < STEPS; k++) side_q[k] <= side_q[k-1];
      for (int k = 0; k < STEPS; k++) begin
        x_q[k] <= x_next[k];
        r_q[k] <= r_next[k];
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign root      = r_q[STEPS-1][ROOT_OUT_W-1:0];
  assign out_side  = side_q[STEPS-1];
endmodule
`default_nettype wire

[rtl/rsi_div.sv]
// Pipelined restoring divider for three lanes sharing one divisor:
// quotient = floor(num * 2^FRAC_BITS / den), num <= den. Depends on rsi_pkg.
`default_nettype none
module rsi_div import rsi_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int SIDE_W    = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [NORM_LANES-1:0][NORM_W-1:0]    num,
  input  logic [LEN_W-1:0]                     den,
  input  logic [SIDE_W-1:0]                    in_side,
  output logic                                 out_valid,
  output logic [NORM_LANES-1:0][FRAC_BITS:0]   quo,
  output logic [SIDE_W-1:0]                    out_side
);
  localparam int STEPS = FRAC_BITS + 1;
  localparam int QW    = FRAC_BITS + 1;

  logic [LEN_W-1:0]                  rem_q    [STEPS][NORM_LANES];
  logic [LEN_W-1:0]                  rem_next [STEPS][NORM_LANES];
  logic [NORM_LANES-1:0][QW-1:0]     quo_q    [STEPS];
  logic [NORM_LANES-1:0][QW-1:0]     quo_next [STEPS];
  logic [LEN_W-1:0]                  den_q    [STEPS];
  logic [SIDE_W-1:0]                 side_q   [STEPS];
  logic [STEPS-1:0]                  vld;

  always_comb begin
    logic [LEN_W:0]   partial;
    logic [LEN_W-1:0] dsrc;
    logic [QW-1:0]    qsrc;
    logic             qbit;
    for (int k = 0; k < STEPS; k++) begin
      dsrc = (k == 0) ? den : den_q[(k == 0) ? 0 : k - 1];
      for (int j = 0; j < NORM_LANES; j++) begin
        if (k == 0) begin
          partial = {{(LEN_W + 1 - NORM_W){1'b0}}, num[j]};
          qsrc    = '0;
        end else begin
          partial = {rem_q[k-1][j], 1'b0};
          qsrc    = quo_q[k-1][j];
        end
        qbit = (partial >= {1'b0, dsrc});
        rem_next[k][j] = qbit ? LEN_W'(partial - {1'b0, dsrc}) : partial[LEN_W-1:0];
        quo_next[k][j] = {qsrc[QW-2:0], qbit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_q[0]  <= den;
      side_q[0] <= in_side;
      for (int k = 1; k < STEPS; k++) begin
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
      for (int k = 0; k < STEPS; k++) begin
        quo_q[k] <= quo_next[k];
        for (int j = 0; j < NORM_LANES; j++) rem_q[k][j] <= rem_next[k][j];
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign quo       = quo_q[STEPS-1];
  assign out_side  = side_q[STEPS-1];
endmodule
`default_nettype wire

[rtl/ray_sphere_intersection.sv]
// Ray/sphere intersection, geometric form, fully pipelined.
// Depends on rsi_pkg, rsi_isqrt (two instances) and rsi_div.
//
//  Channel   Dir  Handshake                     Carries
//  s_axis    in   s_axis_tvalid/s_axis_tready   one ray and one sphere
//  m_axis    out  m_axis_tvalid/m_axis_tready   hit flag, distance, point, normal
//
// One item enters per cycle while the output is not held. The pipeline holds
// 14 arithmetic stages, two 32-stage square root units and a FRAC_BITS+1
// stage divider (FRAC_BITS = 16 for Q16.16), plus the output register.
// rst is synchronous and clears only the valid bits; payload is not reset.
// A held output stalls the whole pipeline in place; s_axis_tready follows
// the output register being empty or taken, so nothing is lost or repeated.
`default_nettype none
module ray_sphere_intersection import rsi_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // center_x, center_y, center_z, sphere_radius, 1 pad bit
  input  logic [319:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_distance, point_x, point_y, point_z, normal_x, normal_y, normal_z, 3 pad bits
  output logic [183:0] m_axis_tdata,
  // hit_found
  output logic         m_axis_tuser
);
  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  typedef struct packed {
    logic             hit;
    logic [31:0]      l;
    logic [2:0][31:0] o;
    logic [2:0][31:0] d;
    logic [2:0][31:0] c;
  } side1_t;

  typedef struct packed {
    logic                              hit;
    logic [30:0]                       t;
    logic [2:0][31:0]                  pt;
    logic [2:0]                        neg;
    logic                              mxz;
    logic [NORM_LANES-1:0][NORM_W-1:0] an;
  } side2_t;

  typedef struct packed {
    logic             hit;
    logic [30:0]      t;
    logic [2:0][31:0] pt;
    logic [2:0]       neg;
    logic             mxz;
  } side3_t;

  // Truncate a fixed-point product toward zero.
  function automatic logic signed [63:0] trunc_q(input logic signed [63:0] p, input int f);
    logic signed [63:0] bias;
    bias = p[63] ? ((64'sd1 <<< f) - 64'sd1) : 64'sd0;
    return (p + bias) >>> f;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] res;
    if (v > MAX32) res = 32'h7FFF_FFFF;
    else if (v < MIN32) res = 32'h8000_0000;
    else res = v[31:0];
    return res;
  endfunction

  // Advance everything whenever the output register is free or being taken.
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Unpack the input item.
  logic [2:0][31:0] in_o, in_d, in_c;
  logic [30:0]      in_r;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_o[i] = s_axis_tdata[32*i +: 32];
      in_d[i] = s_axis_tdata[96 + 32*i +: 32];
      in_c[i] = s_axis_tdata[192 + 32*i +: 32];
    end
    in_r = s_axis_tdata[288 +: 31];
  end

  // Valid bits of the front stages (1..5) and the middle stages (6..14).
  logic [5:1]  vld_a;
  logic [14:6] vld_b;

  // Stage 1: w = center - origin, saturated.
  logic [2:0][31:0] o1, d1, c1, w1, w_next;
  logic [30:0]      r1;
  always_comb begin
    logic [32:0] diff;
    for (int i = 0; i < 3; i++) begin
      diff = {in_c[i][31], in_c[i]} - {in_o[i][31], in_o[i]};
      if (diff[32] != diff[31]) w_next[i] = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else w_next[i] = diff[31:0];
    end
  end

  // Stage 2: raw products.
  logic [2:0][63:0] pdw2, pww2;
  logic [61:0]      prr2;
  logic [2:0][31:0] o2, d2, c2;

  // Stage 3: truncate and sum the dot products.
  logic signed [63:0] lraw3, ww3;
  logic [63:0]        r2_3;
  logic [2:0][31:0]   o3, d3, c3;
  logic signed [63:0] lsum, wwsum;
  always_comb begin
    lsum  = '0;
    wwsum = '0;
    for (int i = 0; i < 3; i++) begin
      lsum  = lsum + trunc_q($signed(pdw2[i]), FRAC_BITS);
      wwsum = wwsum + trunc_q($signed(pww2[i]), FRAC_BITS);
    end
  end

  // Stage 4: saturate l and square it.
  logic [31:0]        l4, lsat;
  logic signed [63:0] lsq4, ww4;
  logic [63:0]        r2_4;
  logic [2:0][31:0]   o4, d4, c4;
  assign lsat = sat32(lraw3);

  // Stage 5: b2, miss test, radicand for the half chord.
  logic [63:0]        rad5, rad_next;
  side1_t             sd5, sd5_next;
  always_comb begin
    logic signed [63:0] l2, b2;
    l2 = lsq4 >>> FRAC_BITS;
    b2 = ww4 - l2;
    if (b2 < 0) b2 = '0;
    rad_next = (r2_4 - b2) << FRAC_BITS;
    sd5_next = side1_t'{hit: !(b2 > $signed(r2_4)), l: l4, o: o4, d: d4, c: c4};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= '0;
    end else if (adv) begin
      vld_a <= {vld_a[4:1], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o1 <= in_o; d1 <= in_d; c1 <= in_c; w1 <= w_next; r1 <= in_r;
      for (int i = 0; i < 3; i++) begin
        pdw2[i] <= $signed(d1[i]) * $signed(w1[i]);
        pww2[i] <= $signed(w1[i]) * $signed(w1[i]);
      end
      prr2 <= r1 * r1;
      o2 <= o1; d2 <= d1; c2 <= c1;
      lraw3 <= lsum; ww3 <= wwsum; r2_3 <= {2'b00, prr2} >> FRAC_BITS;
      o3 <= o2; d3 <= d2; c3 <= c2;
      l4 <= lsat; lsq4 <= $signed(lsat) * $signed(lsat); ww4 <= ww3; r2_4 <= r2_3;
      o4 <= o3; d4 <= d3; c4 <= c3;
      rad5 <= rad_next; sd5 <= sd5_next;
    end
  end

  // Half chord c = sqrt((r2 - b2) * 2^F).
  logic                  v_r1;
  logic [ROOT_OUT_W-1:0] root1;
  logic [$bits(side1_t)-1:0] sd1_raw;
  side1_t                sd1;
  rsi_isqrt #(.SIDE_W($bits(side1_t))) u_chord (
    .clk(clk), .rst(rst), .en(adv), .in_valid(vld_a[5]), .radicand(rad5),
    .in_side(sd5), .out_valid(v_r1), .root(root1), .out_side(sd1_raw)
  );
  assign sd1 = side1_t'(sd1_raw);

  // Stage 6: pick the nearest root that is not negative.
  logic             hit6, hit_next6;
  logic [30:0]      t6, t_next6;
  logic [2:0][31:0] o6, d6, c6;
  always_comb begin
    logic signed [33:0] lx, cx, t1, t2, t;
    lx = {{2{sd1.l[31]}}, sd1.l};
    cx = {2'b00, root1};
    t1 = lx - cx;
    t2 = lx + cx;
    t  = t1[33] ? t2 : t1;
    hit_next6 = sd1.hit && !t[33];
    t_next6   = (t > 34'sd2147483647) ? 31'h7FFF_FFFF : t[30:0];
  end

  // Stage 7: direction times distance.
  logic [2:0][63:0] pdt7;
  logic [2:0][31:0] o7, c7;
  logic             hit7;
  logic [30:0]      t7;

  // Stage 8: hit point.
  logic [2:0][31:0] pt8, c8;
  logic             hit8;
  logic [30:0]      t8;

  // Stage 9: normal vector magnitudes and signs.
  logic [2:0][32:0] a9, a_next9;
  logic [2:0]       neg9, neg_next9;
  logic [2:0][31:0] pt9;
  logic             hit9;
  logic [30:0]      t9;
  always_comb begin
    logic [32:0] vd;
    for (int i = 0; i < 3; i++) begin
      vd = {pt8[i][31], pt8[i]} - {c8[i][31], c8[i]};
      neg_next9[i] = vd[32];
      a_next9[i]   = vd[32] ? (33'd0 - vd) : vd;
    end
  end

  // Stage 10: largest magnitude.
  logic [32:0]      mx10, mx_next10;
  logic [2:0][32:0] a10;
  logic [2:0]       neg10;
  logic [2:0][31:0] pt10;
  logic             hit10;
  logic [30:0]      t10;
  always_comb begin
    mx_next10 = a9[0];
    if (a9[1] > mx_next10) mx_next10 = a9[1];
    if (a9[2] > mx_next10) mx_next10 = a9[2];
  end

  // Stage 11: shift amounts that put the largest magnitude in [2^29, 2^30).
  logic [1:0]       rs11, rs_next11;
  logic [4:0]       ls11, ls_next11;
  logic             mxz11;
  logic [2:0][32:0] a11;
  logic [2:0]       neg11;
  logic [2:0][31:0] pt11;
  logic             hit11;
  logic [30:0]      t11;
  always_comb begin
    logic [5:0] pos;
    pos = '0;
    for (int b = 0; b < 33; b++) if (mx10[b]) pos = 6'(b);
    rs_next11 = (pos > 6'd29) ? 2'(pos - 6'd29) : 2'd0;
    ls_next11 = (pos < 6'd29) ? 5'(6'd29 - pos) : 5'd0;
  end

  // Stage 12: normalize.
  logic [NORM_LANES-1:0][NORM_W-1:0] an12;
  logic             mxz12;
  logic [2:0]       neg12;
  logic [2:0][31:0] pt12;
  logic             hit12;
  logic [30:0]      t12;

  // Stage 13: squares.
  logic [2:0][59:0] sq13;
  logic [NORM_LANES-1:0][NORM_W-1:0] an13;
  logic             mxz13;
  logic [2:0]       neg13;
  logic [2:0][31:0] pt13;
  logic             hit13;
  logic [30:0]      t13;

  // Stage 14: sum of squares.
  logic [63:0]      sum14;
  side2_t           sd14;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= '0;
    end else if (adv) begin
      vld_b <= {vld_b[13:6], v_r1};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit6 <= hit_next6; t6 <= t_next6; o6 <= sd1.o; d6 <= sd1.d; c6 <= sd1.c;
      for (int i = 0; i < 3; i++) pdt7[i] <= $signed(d6[i]) * $signed({1'b0, t6});
      o7 <= o6; c7 <= c6; hit7 <= hit6; t7 <= t6;
      for (int i = 0; i < 3; i++)
        pt8[i] <= sat32($signed({{32{o7[i][31]}}, o7[i]}) + trunc_q($signed(pdt7[i]), FRAC_BITS));
      c8 <= c7; hit8 <= hit7; t8 <= t7;
      a9 <= a_next9; neg9 <= neg_next9; pt9 <= pt8; hit9 <= hit8; t9 <= t8;
      mx10 <= mx_next10; a10 <= a9; neg10 <= neg9; pt10 <= pt9; hit10 <= hit9; t10 <= t9;
      rs11 <= rs_next11; ls11 <= ls_next11; mxz11 <= (mx10 == '0);
      a11 <= a10; neg11 <= neg10; pt11 <= pt10; hit11 <= hit10; t11 <= t10;
      for (int i = 0; i < 3; i++)
        an12[i] <= NORM_W'(({31'b0, a11[i]} >> rs11) << ls11);
      mxz12 <= mxz11; neg12 <= neg11; pt12 <= pt11; hit12 <= hit11; t12 <= t11;
      for (int i = 0; i < 3; i++) sq13[i] <= an12[i] * an12[i];
      an13 <= an12; mxz13 <= mxz12; neg13 <= neg12; pt13 <= pt12; hit13 <= hit12; t13 <= t12;
      sum14 <= {4'b0, sq13[0]} + {4'b0, sq13[1]} + {4'b0, sq13[2]};
      sd14  <= side2_t'{hit: hit13, t: t13, pt: pt13, neg: neg13, mxz: mxz13, an: an13};
    end
  end

  // Length of the normalized normal vector.
  logic                  v_r2;
  logic [ROOT_OUT_W-1:0] len;
  logic [$bits(side2_t)-1:0] sd2_raw;
  side2_t                sd2;
  rsi_isqrt #(.SIDE_W($bits(side2_t))) u_length (
    .clk(clk), .rst(rst), .en(adv), .in_valid(vld_b[14]), .radicand(sum14),
    .in_side(sd14), .out_valid(v_r2), .root(len), .out_side(sd2_raw)
  );
  assign sd2 = side2_t'(sd2_raw);

  // Unit normal components.
  logic                                v_q;
  logic [NORM_LANES-1:0][FRAC_BITS:0]  quo;
  logic [$bits(side3_t)-1:0]           sd3_raw;
  side3_t                              sd3;
  rsi_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(side3_t))) u_norm (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v_r2), .num(sd2.an), .den(LEN_W'(len)),
    .in_side(side3_t'{hit: sd2.hit, t: sd2.t, pt: sd2.pt, neg: sd2.neg, mxz: sd2.mxz}),
    .out_valid(v_q), .quo(quo), .out_side(sd3_raw)
  );
  assign sd3 = side3_t'(sd3_raw);

  // Output register: drop everything to zero on a miss.
  logic [183:0] data_next;
  always_comb begin
    logic [63:0]      qc;
    logic [63:0]      nv;
    logic [2:0][17:0] nrm;
    for (int i = 0; i < 3; i++) begin
      qc = 64'(quo[i]);
      if (qc > (64'd1 << FRAC_BITS)) qc = 64'd1 << FRAC_BITS;
      nv = sd3.neg[i] ? (64'd0 - qc) : qc;
      nrm[i] = sd3.mxz ? 18'd0 : nv[17:0];
    end
    if (sd3.hit) data_next = {3'b000, nrm[2], nrm[1], nrm[0],
                              sd3.pt[2], sd3.pt[1], sd3.pt[0], sd3.t};
    else data_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= v_q;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= data_next;
      m_axis_tuser <= sd3.hit;
    end
  end

  // A miss carries an all-zero payload.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss item with nonzero payload");

  // Normalization puts the largest magnitude at bit 29.
  a_norm_top: assert property (@(posedge clk) disable iff (rst)
    vld_b[12] && !mxz12 |-> (an12[0][29] || an12[1][29] || an12[2][29]))
    else $error("normal vector not normalized");

  // Length of a normalized nonzero vector lies at or above 2^29.
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    v_r2 && !sd2.mxz |-> len[31:29] != 3'b000)
    else $error("normal length out of range");
endmodule
`default_nettype wire
